@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define WTLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define WTLP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/wtlp_pkg.sv @@
// ----------------------------------------------------------------------------
// wtlp_pkg
// Types and constants of the wheel target line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wtlp_pkg;

   localparam int BUFFER_BYTES = 64;
   localparam int CNT_W        = $clog2(BUFFER_BYTES);

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_EMPTY  = 3'd1;
   localparam logic [2:0] ST_PREFIX = 3'd2;
   localparam logic [2:0] ST_FIELDS = 3'd3;
   localparam logic [2:0] ST_NUMBER = 3'd4;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] target_0;
      logic signed [15:0] target_1;
      logic signed [15:0] target_2;
      logic signed [15:0] target_3;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/wtlp_req_reg.sv @@
// ----------------------------------------------------------------------------
// wtlp_req_reg
// Input register: holds one request until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wtlp_req_reg
   import wtlp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  wire     take,
   output logic    valid,
   output req_type data
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/wtlp_parser.sv @@
// ----------------------------------------------------------------------------
// wtlp_parser
// Line state and per-character token logic; builds the end-of-line result.
// ----------------------------------------------------------------------------
`default_nettype none

module wtlp_parser
   import wtlp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     step,
   input  req_type req,
   output rsp_type rsp
);

   localparam logic [1:0] PH_LEAD  = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] TOK_MAX  = 3'd5;
   localparam logic [2:0] TOK_PFX  = 3'd1;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             stop_ff, stop_in;
   logic             saw_ff, saw_in;
   logic [2:0]       tok_ff, tok_in;
   logic             inside_ff, inside_in;
   logic [2:0]       err_ff, err_in;
   logic [1:0]       phase_ff, phase_in;
   logic             bad_ff, bad_in;
   logic             neg_ff, neg_in;
   logic [15:0]      mag_ff, mag_in;
   logic [15:0]      targets_ff [4];
   logic [15:0]      targets_in [4];

   always_comb begin
      logic       blocked;
      logic       close;
      logic       digit;
      logic       space;
      logic       fits;
      logic [19:0] acc;
      logic [2:0] tidx;
      logic [2:0] status;

      cnt_in     = cnt_ff;
      stop_in    = stop_ff;
      saw_in     = saw_ff;
      tok_in     = tok_ff;
      inside_in  = inside_ff;
      err_in     = err_ff;
      phase_in   = phase_ff;
      bad_in     = bad_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      targets_in = targets_ff;
      close      = 1'b0;

      blocked = stop_ff || (cnt_ff >= CNT_W'(BUFFER_BYTES - 1));
      digit   = (req.ch >= 8'h30) && (req.ch <= 8'h39);
      space   = (req.ch == CH_SPACE) || ((req.ch >= 8'h09) && (req.ch <= 8'h0D));
      acc     = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {16'b0, req.ch[3:0]};

      if (step) begin
         if (req.kind == KIND_CHAR) begin
            if (!blocked) begin
               if (req.ch == CH_NUL) begin
                  stop_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  saw_in = 1'b1;
                  if (req.ch == CH_COMMA) begin
                     close = inside_ff;
                  end else begin
                     if (!inside_ff) begin
                        inside_in = 1'b1;
                        phase_in  = PH_LEAD;
                        bad_in    = 1'b0;
                        neg_in    = 1'b0;
                        mag_in    = 16'd0;
                        if (tok_ff < TOK_MAX) begin
                           tok_in = tok_ff + 3'd1;
                        end else if (err_in == ST_OK) begin
                           err_in = ST_FIELDS;
                        end
                     end
                     // feed the open token
                     if (!bad_in) begin
                        if (tok_in == TOK_PFX) begin
                           if (phase_in == PH_LEAD && req.ch == CH_W) begin
                              phase_in = PH_SIGN;
                           end else begin
                              bad_in = 1'b1;
                           end
                        end else if (digit) begin
                           if (!inside_ff) begin
                              acc = {16'b0, req.ch[3:0]};
                           end
                           mag_in   = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                           phase_in = PH_DIGIT;
                        end else if (phase_in == PH_LEAD && space) begin
                           bad_in = 1'b0;
                        end else if (phase_in == PH_LEAD &&
                                     (req.ch == CH_PLUS || req.ch == CH_MINUS)) begin
                           neg_in   = (req.ch == CH_MINUS);
                           phase_in = PH_SIGN;
                        end else begin
                           bad_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end else begin
            close = inside_ff;
         end
      end

      // close the open token
      fits = neg_ff ? (mag_ff <= 16'd32768) : (mag_ff <= 16'd32767);
      tidx = tok_ff - 3'd2;
      if (close) begin
         inside_in = 1'b0;
         if (tok_ff == TOK_PFX) begin
            if ((bad_ff || phase_ff != PH_SIGN) && err_in == ST_OK) begin
               err_in = ST_PREFIX;
            end
         end else if (bad_ff || phase_ff != PH_DIGIT || !fits) begin
            if (err_in == ST_OK) begin
               err_in = ST_NUMBER;
            end
         end else begin
            targets_in[tidx[1:0]] = neg_ff ? (16'd0 - mag_ff) : mag_ff;
         end
      end

      if (!saw_ff) begin
         status = ST_EMPTY;
      end else if (err_in != ST_OK) begin
         status = err_in;
      end else if (tok_ff == 3'd0) begin
         status = ST_PREFIX;
      end else if (tok_ff < TOK_MAX) begin
         status = ST_FIELDS;
      end else begin
         status = ST_OK;
      end

      rsp.status   = status;
      rsp.target_0 = (status == ST_OK) ? targets_in[0] : 16'sd0;
      rsp.target_1 = (status == ST_OK) ? targets_in[1] : 16'sd0;
      rsp.target_2 = (status == ST_OK) ? targets_in[2] : 16'sd0;
      rsp.target_3 = (status == ST_OK) ? targets_in[3] : 16'sd0;

      // drop the line state, but for the stored targets, after the answer
      if (step && req.kind == KIND_EOL) begin
         cnt_in    = '0;
         stop_in   = 1'b0;
         saw_in    = 1'b0;
         tok_in    = 3'd0;
         inside_in = 1'b0;
         err_in    = ST_OK;
         phase_in  = PH_LEAD;
         bad_in    = 1'b0;
         neg_in    = 1'b0;
         mag_in    = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         stop_ff   <= 1'b0;
         saw_ff    <= 1'b0;
         tok_ff    <= 3'd0;
         inside_ff <= 1'b0;
         err_ff    <= ST_OK;
         phase_ff  <= PH_LEAD;
         bad_ff    <= 1'b0;
         neg_ff    <= 1'b0;
         mag_ff    <= 16'd0;
      end else begin
         cnt_ff    <= cnt_in;
         stop_ff   <= stop_in;
         saw_ff    <= saw_in;
         tok_ff    <= tok_in;
         inside_ff <= inside_in;
         err_ff    <= err_in;
         phase_ff  <= phase_in;
         bad_ff    <= bad_in;
         neg_ff    <= neg_in;
         mag_ff    <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      targets_ff <= targets_in;
   end

endmodule

`default_nettype wire

@@ rtl/wtlp_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// wtlp_rsp_reg
// Result register: holds the line answer until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wtlp_rsp_reg
   import wtlp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     load,
   input  rsp_type data,
   output logic    free,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = data;
      end else if (free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/wheel_target_line_parser.sv @@
// ----------------------------------------------------------------------------
// wheel_target_line_parser
// Comma separated "W,a,b,c,d" command line parser, one character per request.
// ----------------------------------------------------------------------------
// Each request carries one line character or an end-of-line mark. A line
// answers once, at its end-of-line request, with a status (ok, empty, bad
// prefix, bad field count, bad number) and four signed 16-bit targets that
// are zero unless the status is ok. One request is taken every clock cycle;
// a request waits in the input register until the parser takes it, and the
// answer is in the result register in the cycle after the end-of-line request
// is taken. Throughput drops only while a finished answer sits stalled in the
// result register with an end-of-line request behind it; later requests wait too.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wheel_target_line_parser
   import wtlp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   logic    held_valid;
   req_type held;
   logic    take;
   logic    free;
   logic    eol_take;
   rsp_type answer;
   logic    rsp_targets_zero;

   assign take     = held_valid && (held.kind == KIND_CHAR || free);
   assign eol_take = take && held.kind == KIND_EOL;

   wtlp_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .valid     (held_valid),
      .data      (held)
   );

   wtlp_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (take),
      .req   (held),
      .rsp   (answer)
   );

   wtlp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (eol_take),
      .data      (answer),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_targets_zero = (rsp_data.target_0 == 16'sd0) && (rsp_data.target_1 == 16'sd0) &&
                             (rsp_data.target_2 == 16'sd0) && (rsp_data.target_3 == 16'sd0);

   `WTLP_ASSERT(a_eol_needs_room, clock, reset, eol_take |-> free, "answer overwritten")
   `WTLP_ASSERT(a_eol_gives_rsp, clock, reset, eol_take |=> rsp_valid, "answer lost")
   `WTLP_ASSERT_NEVER(a_error_zero_targets, clock, reset, rsp_valid && rsp_data.status != ST_OK && !rsp_targets_zero, "targets set on error")

endmodule

`default_nettype wire

@@ dv/wheel_target_line_parser_test.sv @@
// ----------------------------------------------------------------------------
// wheel_target_line_parser_test
// Line parser check: command lines are streamed one request per character and
// closed by an end-of-line request. Each answer is compared field by field
// with a local parse of the same line. Covers corner lines, long lines, random
// well-formed and broken lines, a long result hold-off and back-to-back flow.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_target_line_parser_test;
   import wtlp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_W     = 8'h57;

   localparam logic [2:0] NO_ERROR = 3'd0;

   typedef enum int unsigned {PH_LEAD, PH_SIGN, PH_DIGITS} field_phase_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   wheel_target_line_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // line parse state
   int unsigned        line_len;
   bit                 line_halted;
   bit                 line_has_content;
   int unsigned        field_count;
   bit                 field_open;
   logic [2:0]         line_error;
   field_phase_type    field_phase;
   bit                 field_bad;
   bit                 field_negative;
   int unsigned        field_magnitude;
   logic signed [15:0] wheel_value [4];

   rsp_type     expected_answers[$];
   logic [7:0]  line_buf[$];
   int unsigned requests_sent;
   int unsigned error_count;
   bit          send_idle_en;
   bit          recv_idle_en;
   int unsigned hold_left;
   int unsigned stall_left;

   function automatic void clear_line();
      line_len         = 0;
      line_halted      = 1'b0;
      line_has_content = 1'b0;
      field_count      = 0;
      field_open       = 1'b0;
      line_error       = NO_ERROR;
      field_phase      = PH_LEAD;
      field_bad        = 1'b0;
      field_negative   = 1'b0;
      field_magnitude  = 0;
   endfunction

   function automatic void flag_error(input logic [2:0] code);
      if (line_error == NO_ERROR) line_error = code;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void close_field();
      int unsigned idx;
      bit          fits;
      int          value;
      idx = field_count - 1;
      field_open = 1'b0;
      if (idx == 0) begin
         if (field_bad || field_phase != PH_SIGN) flag_error(ST_PREFIX);
      end else if (idx <= 4) begin
         fits = field_negative ? (field_magnitude <= 32768) : (field_magnitude <= 32767);
         if (field_bad || field_phase != PH_DIGITS || !fits) begin
            flag_error(ST_NUMBER);
         end else begin
            value = field_negative ? -int'(field_magnitude) : int'(field_magnitude);
            wheel_value[idx - 1] = value[15:0];
         end
      end
   endfunction

   function automatic void feed_field(input logic [7:0] c);
      int unsigned idx;
      int unsigned acc;
      idx = field_count - 1;
      if (field_bad) return;
      if (idx == 0) begin
         if (field_phase == PH_LEAD && c == CH_W) field_phase = PH_SIGN;
         else field_bad = 1'b1;
         return;
      end
      if (idx > 4) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         acc = field_magnitude * 10 + (c - CH_ZERO);
         field_magnitude = (acc > 65535) ? 65535 : acc;
         field_phase = PH_DIGITS;
      end else if (field_phase == PH_LEAD && is_blank(c)) begin
      end else if (field_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
         field_negative = (c == CH_MINUS);
         field_phase = PH_SIGN;
      end else begin
         field_bad = 1'b1;
      end
   endfunction

   function automatic void take_char(input logic [7:0] c);
      if (line_halted || line_len >= BUFFER_BYTES - 1) return;
      if (c == CH_NUL) begin
         line_halted = 1'b1;
         return;
      end
      line_len++;
      line_has_content = 1'b1;
      if (c == CH_COMMA) begin
         if (field_open) close_field();
         return;
      end
      if (!field_open) begin
         field_open      = 1'b1;
         field_phase     = PH_LEAD;
         field_bad       = 1'b0;
         field_negative  = 1'b0;
         field_magnitude = 0;
         if (field_count < 5) field_count++;
         else flag_error(ST_FIELDS);
      end
      feed_field(c);
   endfunction

   function automatic void parse_request(input req_type r);
      rsp_type ans;
      bit      ok;
      if (r.kind == KIND_CHAR) begin
         take_char(r.ch);
         return;
      end
      if (field_open) close_field();
      if (!line_has_content) ans.status = ST_EMPTY;
      else if (line_error != NO_ERROR) ans.status = line_error;
      else if (field_count == 0) ans.status = ST_PREFIX;
      else if (field_count < 5) ans.status = ST_FIELDS;
      else ans.status = ST_OK;
      ok = (ans.status == ST_OK);
      ans.target_0 = ok ? wheel_value[0] : '0;
      ans.target_1 = ok ? wheel_value[1] : '0;
      ans.target_2 = ok ? wheel_value[2] : '0;
      ans.target_3 = ok ? wheel_value[3] : '0;
      expected_answers.push_back(ans);
      clear_line();
   endfunction

   task automatic send_request(input logic kind, input logic [7:0] ch);
      if (send_idle_en && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{kind: kind, ch: ch};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_request(req_data);
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_blank();
      int unsigned k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CH_SPACE : CH_TAB + k[7:0];
   endfunction

   task automatic send_line_buf();
      foreach (line_buf[i]) send_request(KIND_CHAR, line_buf[i]);
      send_request(KIND_EOL, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_line(input string s);
      line_buf.delete();
      add_text(s);
      send_line_buf();
   endtask

   task automatic wait_for_answers();
      while (expected_answers.size() != 0) @(negedge clock);
   endtask

   function automatic void add_number();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) line_buf.push_back(pick_blank());
      case ($urandom_range(0, 3))
         0: line_buf.push_back(CH_MINUS);
         1: line_buf.push_back(CH_PLUS);
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0: add_text($sformatf("%0d", $urandom_range(0, 9)));
         1: add_text($sformatf("%0d", $urandom_range(0, 999)));
         2, 3: add_text($sformatf("%0d", $urandom_range(0, 32767)));
         4: add_text($sformatf("%0d", $urandom_range(32760, 32775)));
         5: add_text($sformatf("%0d", $urandom_range(32767, 32768)));
         6: add_text($sformatf("%0d", $urandom_range(0, 99999)));
         7: repeat ($urandom_range(6, 12)) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         8: add_text($sformatf("000%0d", $urandom_range(0, 999)));
         default: ;
      endcase
      if ($urandom_range(0, 11) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void fill_random_line();
      int unsigned n_fields;
      line_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_COMMA);
      case ($urandom_range(0, 15))
         0: add_text("w");
         1: add_text("WW");
         2: add_text(" W");
         3: line_buf.push_back(8'($urandom_range(0, 255)));
         4: ;
         default: add_text("W");
      endcase
      n_fields = ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(0, 6);
      repeat (n_fields) begin
         line_buf.push_back(CH_COMMA);
         if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_COMMA);
         add_number();
      end
      if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_COMMA);
      if ($urandom_range(0, 11) == 0) begin
         while (line_buf.size() < 62) line_buf.push_back(CH_COMMA);
         add_text($sformatf(",%0d", $urandom_range(0, 99)));
      end
      if ($urandom_range(0, 11) == 0) line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
   endfunction

   task automatic test_corner_lines();
      send_line("");
      send_line(",,");
      send_line("W,1");
      line_buf.delete();
      add_text("W,\t-32768, 32767,+0,");
      line_buf.push_back(CH_CR);
      add_text("0009");
      line_buf.push_back(CH_NUL);
      add_text(",x");
      send_line_buf();
      send_line("W,1,2,3,4,5");
      send_line("W,x,1,2,3,4");
      send_line("W,32768,-32769,1,99999");
      send_line("w,1,2,3,4");
      send_line("W,-,1 ,2,3");
      send_line(",W,,1,,2,3,-4,");
   endtask

   task automatic test_long_lines();
      line_buf.delete();
      add_text("W,1,2,3,4");
      while (line_buf.size() < 63) line_buf.push_back(CH_COMMA);
      add_text(",9,bad");
      send_line_buf();
      line_buf.delete();
      add_text("W,-1,2,3,");
      while (line_buf.size() < 62) line_buf.push_back(CH_COMMA);
      add_text("45");
      line_buf.push_back(CH_NUL);
      send_line_buf();
   endtask

   task automatic test_random_lines(input int unsigned n_requests);
      int unsigned start_req;
      start_req = requests_sent;
      while (requests_sent - start_req < n_requests) begin
         fill_random_line();
         send_line_buf();
      end
   endtask

   task automatic test_backpressure();
      hold_left = 300;
      repeat (8) begin
         fill_random_line();
         send_line_buf();
      end
      wait_for_answers();
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         fill_random_line();
         send_line_buf();
      end
      wait_for_answers();
      repeat (3) begin
         fill_random_line();
         send_line_buf();
      end
   endtask

   task automatic test_streaming();
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      test_random_lines(150);
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      if (error_count < 10)
         $display("%0t mismatch on %s: expected %0d actual %0d", $realtime, what, want, got);
      error_count++;
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin : check_answers
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected answer status", 0, int'(rsp_data.status));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", int'(want.status), int'(rsp_data.status));
            if (rsp_data.target_0 !== want.target_0)
               report_mismatch("target_0", int'(want.target_0), int'(rsp_data.target_0));
            if (rsp_data.target_1 !== want.target_1)
               report_mismatch("target_1", int'(want.target_1), int'(rsp_data.target_1));
            if (rsp_data.target_2 !== want.target_2)
               report_mismatch("target_2", int'(want.target_2), int'(rsp_data.target_2));
            if (rsp_data.target_3 !== want.target_3)
               report_mismatch("target_3", int'(want.target_3), int'(rsp_data.target_3));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("wheel_target_line_parser_test: errors");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      hold_left     = 0;
      stall_left    = 0;
      requests_sent = 0;
      error_count   = 0;
      send_idle_en  = 1'b1;
      recv_idle_en  = 1'b1;
      foreach (wheel_value[i]) wheel_value[i] = '0;
      clear_line();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_lines();
      test_long_lines();
      test_random_lines(350);
      test_backpressure();
      test_drain_pause();
      test_streaming();

      wait_for_answers();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("wheel_target_line_parser_test: clean");
      end else begin
         $display("wheel_target_line_parser_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
